FILE: sv/msgt_pkg.sv
`timescale 1ns / 1ps
// Shared types, token kinds and lead byte decode for the MessagePack tokenizer.
package msgt_pkg;

	typedef enum logic [3:0] {
		K_NIL     = 4'd0,
		K_RSVD    = 4'd1,
		K_FALSE   = 4'd2,
		K_TRUE    = 4'd3,
		K_UINT    = 4'd4,
		K_INT     = 4'd5,
		K_F32     = 4'd6,
		K_F64     = 4'd7,
		K_STR     = 4'd8,
		K_BIN     = 4'd9,
		K_EXT     = 4'd10,
		K_ARRAY   = 4'd11,
		K_MAP     = 4'd12,
		K_PAYLOAD = 4'd13
	} kind_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_RD   = 5'b00100,
		S_CHK  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	localparam logic [7:0] FIX_NEG_BASE = 8'hE0;
	localparam logic [7:0] FIX_MAP_BASE = 8'h80;
	localparam int unsigned LEN_W = 33;

	// Number of big-endian bytes that follow a lead byte.
	function automatic logic [3:0] hdr_len(input logic [7:0] b);
		logic [3:0] n;
		unique case (b)
			8'hCC, 8'hD0, 8'hC4, 8'hC7, 8'hD9: n = 4'd1;
			8'hCD, 8'hD1, 8'hC5, 8'hC8, 8'hDA, 8'hDC, 8'hDE: n = 4'd2;
			8'hCE, 8'hD2, 8'hCA, 8'hC6, 8'hC9, 8'hDB, 8'hDD, 8'hDF: n = 4'd4;
			8'hCF, 8'hD3, 8'hCB: n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

FILE: sv/msgt_if.sv
`timescale 1ns / 1ps
// Channel interfaces: input bytes, output tokens and the configuration write.
interface msgt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface msgt_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [63:0] value;
	logic [7:0]  ext_type;
	logic [4:0]  depth;
	logic [4:0]  closed_count;
	logic        root_done;
	logic        depth_overflow;
	modport source (output valid, output kind, output value, output ext_type, output depth,
		output closed_count, output root_done, output depth_overflow, input ready);
	modport sink (input valid, input kind, input value, input ext_type, input depth,
		input closed_count, input root_done, input depth_overflow, output ready);
endinterface

interface msgt_cfg_if;
	logic valid;
	logic ready;
	logic track_nesting;
	modport source (output valid, output track_nesting, input ready);
	modport sink (input valid, input track_nesting, output ready);
endinterface

FILE: sv/msgt_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with registered read.
module msgt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/msgpack_stream_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the streaming MessagePack tokenizer.
//
// Usage: feed the stream one byte per request on the bytes channel. Each
// byte gives at most one token on the tokens channel: a scalar, a str, bin,
// ext or container header, or one payload byte. Header and number bytes that
// are still being gathered give no token.
// Flow: a byte that gives no token passes through capture and decode, one
// that gives a token through capture, decode and emit. A token that finishes
// an object inside an open container passes a check step, then a read and a
// further check for each level it pops, unless that pop empties the stack;
// the walk reuses one 33-bit decrement and compare against the level count
// memory, one level per read. Bytes are refused until the token is loaded.
// The output register then holds the token, so the next byte is taken while
// a token still waits. A stalled receiver holds the token; a second token
// waits in the emit state and bytes stop until the register frees.
// Configuration: cfg is ready out of reset; write track_nesting only while idle.
// Reset: stack empty, all gathering state cleared, track_nesting set, both
// inputs refused. The level memory needs no clearing, since an entry is always
// written on push before it is read.
module msgpack_stream_tokenizer
	import msgt_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	msgt_byte_if.sink  bytes,
	msgt_tok_if.source tokens,
	msgt_cfg_if.sink   cfg
);
	localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int unsigned TW = $clog2(MAX_DEPTH + 1);

	state_t state_q;
	logic [7:0]       byte_q;
	logic [TW-1:0]    top_q;
	logic [TW-1:0]    closed_q;
	logic [7:0]       tag_q;
	logic [3:0]       hdr_q;
	logic [63:0]      acc_q;
	logic [LEN_W-1:0] pay_q;
	logic             ext_q;
	logic             track_q;

	// token under construction
	kind_t       tk_kind_q;
	logic [63:0] tk_val_q;
	logic [7:0]  tk_ext_q;
	logic [4:0]  tk_depth_q;
	logic        tk_done_q;
	logic        tk_ovf_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  o_kind_q;
	logic [63:0] o_val_q;
	logic [7:0]  o_ext_q;
	logic [4:0]  o_depth_q;
	logic [4:0]  o_closed_q;
	logic        o_root_q;
	logic        o_ovf_q;

	// decode results
	logic             d_emit, d_done, d_ovf, d_push;
	kind_t            d_kind;
	logic [63:0]      d_val;
	logic [7:0]       d_ext;
	logic [LEN_W-1:0] d_count;
	logic [LEN_W-1:0] pay_n;
	logic             ext_n;
	logic [3:0]       hdr_n;
	logic [63:0]      acc_n;
	logic [7:0]       tag_n;
	logic             is_cont, is_data;
	kind_t            c_kind;
	logic [63:0]      len, v;

	// level memory
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [LEN_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [LEN_W-1:0] ram_rdata;
	logic             lvl_last;
	logic             out_free;

	assign bytes.ready = arst_n && (state_q == S_IDLE);
	assign cfg.ready   = arst_n;
	assign out_free    = !out_valid_q || tokens.ready;

	assign tokens.valid          = out_valid_q;
	assign tokens.kind           = o_kind_q;
	assign tokens.value          = o_val_q;
	assign tokens.ext_type       = o_ext_q;
	assign tokens.depth          = o_depth_q;
	assign tokens.closed_count   = o_closed_q;
	assign tokens.root_done      = o_root_q;
	assign tokens.depth_overflow = o_ovf_q;

	// Decode of the captured byte against the gathering state.
	always_comb begin
		d_emit  = 1'b0;
		d_done  = 1'b0;
		d_ovf   = 1'b0;
		d_push  = 1'b0;
		d_kind  = K_NIL;
		d_val   = '0;
		d_ext   = '0;
		d_count = '0;
		pay_n   = pay_q;
		ext_n   = ext_q;
		hdr_n   = hdr_q;
		acc_n   = acc_q;
		tag_n   = tag_q;
		is_cont = 1'b0;
		is_data = 1'b0;
		c_kind  = K_MAP;
		len     = '0;
		v       = {acc_q[55:0], byte_q};
		if (pay_q != '0) begin
			// pass a payload byte through
			pay_n  = pay_q - 1'b1;
			d_emit = 1'b1;
			d_kind = K_PAYLOAD;
			d_val  = {56'd0, byte_q};
			d_done = (pay_q == LEN_W'(1));
		end else if (ext_q) begin
			// type byte of an ext: emit its header now
			ext_n  = 1'b0;
			pay_n  = acc_q[LEN_W-1:0];
			d_emit = 1'b1;
			d_kind = K_EXT;
			d_val  = acc_q;
			d_ext  = byte_q;
			d_done = (acc_q[LEN_W-1:0] == '0);
		end else if (hdr_q != '0) begin
			acc_n = v;
			hdr_n = hdr_q - 1'b1;
			if (hdr_q == 4'd1) begin
				case (tag_q) inside
					[8'hCC:8'hCF]: begin
						d_emit = 1'b1; d_done = 1'b1; d_kind = K_UINT; d_val = v;
					end
					[8'hD0:8'hD3]: begin
						d_emit = 1'b1; d_done = 1'b1; d_kind = K_INT;
						case (tag_q[1:0])
							2'd0: d_val = {{56{v[7]}}, v[7:0]};
							2'd1: d_val = {{48{v[15]}}, v[15:0]};
							2'd2: d_val = {{32{v[31]}}, v[31:0]};
							default: d_val = v;
						endcase
					end
					8'hCA: begin
						d_emit = 1'b1; d_done = 1'b1; d_kind = K_F32; d_val = v;
					end
					8'hCB: begin
						d_emit = 1'b1; d_done = 1'b1; d_kind = K_F64; d_val = v;
					end
					[8'hC4:8'hC6]: begin
						is_data = 1'b1; c_kind = K_BIN; len = v;
					end
					[8'hD9:8'hDB]: begin
						is_data = 1'b1; c_kind = K_STR; len = v;
					end
					[8'hC7:8'hC9]: ext_n = 1'b1;
					8'hDC, 8'hDD: begin
						is_cont = 1'b1; c_kind = K_ARRAY; len = v;
					end
					default: begin
						is_cont = 1'b1; c_kind = K_MAP; len = v;
					end
				endcase
			end
		end else if (byte_q < FIX_MAP_BASE) begin
			d_emit = 1'b1; d_done = 1'b1; d_kind = K_UINT; d_val = {56'd0, byte_q};
		end else if (byte_q >= FIX_NEG_BASE) begin
			d_emit = 1'b1; d_done = 1'b1; d_kind = K_INT; d_val = {{56{1'b1}}, byte_q};
		end else if (byte_q < 8'h90) begin
			is_cont = 1'b1; c_kind = K_MAP; len = {60'd0, byte_q[3:0]};
		end else if (byte_q < 8'hA0) begin
			is_cont = 1'b1; c_kind = K_ARRAY; len = {60'd0, byte_q[3:0]};
		end else if (byte_q < 8'hC0) begin
			is_data = 1'b1; c_kind = K_STR; len = {59'd0, byte_q[4:0]};
		end else if (byte_q <= 8'hC3) begin
			d_emit = 1'b1; d_done = 1'b1; d_kind = kind_t'({2'b00, byte_q[1:0]});
		end else if (byte_q >= 8'hD4 && byte_q <= 8'hD8) begin
			// fixext: length known from the lead byte
			tag_n = byte_q;
			acc_n = 64'd1 << (byte_q - 8'hD4);
			ext_n = 1'b1;
		end else begin
			tag_n = byte_q;
			acc_n = '0;
			hdr_n = hdr_len(byte_q);
		end

		if (is_data) begin
			pay_n  = len[LEN_W-1:0];
			d_emit = 1'b1;
			d_kind = c_kind;
			d_val  = len;
			d_done = (len == '0);
		end
		if (is_cont) begin
			d_count = (c_kind == K_MAP) ? {len[LEN_W-2:0], 1'b0} : len[LEN_W-1:0];
			d_emit  = 1'b1;
			d_kind  = c_kind;
			d_val   = len;
			if (track_q && d_count != '0) begin
				if (top_q < TW'(MAX_DEPTH)) begin
					d_push = 1'b1;
				end else begin
					d_done = 1'b1;
					d_ovf  = 1'b1;
				end
			end else begin
				d_done = 1'b1;
			end
		end
	end

	// Shared decrement and compare on the top level count.
	assign lvl_last  = (ram_rdata <= LEN_W'(1));
	assign ram_raddr = AW'(top_q - 1'b1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(top_q - 1'b1);
		ram_wdata = ram_rdata - 1'b1;
		if (state_q == S_DEC && d_push) begin
			ram_we    = 1'b1;
			ram_waddr = top_q[AW-1:0];
			ram_wdata = d_count;
		end else if (state_q == S_CHK && !lvl_last) begin
			ram_we = 1'b1;
		end
	end

	msgt_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MAX_DEPTH)
	) u_lvl_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			closed_q    <= '0;
			tag_q       <= '0;
			hdr_q       <= '0;
			acc_q       <= '0;
			pay_q       <= '0;
			ext_q       <= 1'b0;
			track_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				track_q <= cfg.track_nesting;
			end
			// load a new token or drop the one just taken
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (bytes.valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					pay_q    <= pay_n;
					ext_q    <= ext_n;
					hdr_q    <= hdr_n;
					acc_q    <= acc_n;
					tag_q    <= tag_n;
					closed_q <= '0;
					if (d_push) begin
						top_q <= top_q + 1'b1;
					end
					if (!d_emit) begin
						state_q <= S_IDLE;
					end else if (d_done && top_q != '0) begin
						// read issued this cycle at top - 1
						state_q <= S_CHK;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (lvl_last) begin
						// pop this level and walk down
						top_q    <= top_q - 1'b1;
						closed_q <= closed_q + 1'b1;
						state_q  <= (top_q == TW'(1)) ? S_EMIT : S_RD;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Token fields and the output register: payload only, no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && bytes.valid) begin
			byte_q <= bytes.in_byte;
		end
		if (state_q == S_DEC) begin
			tk_kind_q  <= d_kind;
			tk_val_q   <= d_val;
			tk_ext_q   <= d_ext;
			tk_depth_q <= 5'(top_q);
			tk_done_q  <= d_done;
			tk_ovf_q   <= d_ovf;
		end
		if (state_q == S_EMIT && out_free) begin
			o_kind_q   <= tk_kind_q;
			o_val_q    <= tk_val_q;
			o_ext_q    <= tk_ext_q;
			o_depth_q  <= tk_depth_q;
			o_closed_q <= 5'(closed_q);
			o_root_q   <= tk_done_q && (top_q == '0);
			o_ovf_q    <= tk_ovf_q;
		end
	end

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TW'(MAX_DEPTH))
		else $error("stack pointer beyond depth");

	a_chk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> top_q != '0)
		else $error("level walk on an empty stack");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("token loaded outside the emit step");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK && lvl_last |=> closed_q == $past(closed_q) + 1'b1)
		else $error("pop not counted");
endmodule

FILE: verif/msgt_token_checker.sv
`timescale 1ns / 1ps
// Token predictor and scoreboard for the MessagePack tokenizer.
module msgt_token_checker
	import msgt_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	msgt_byte_if.source bytes_mon,
	msgt_tok_if.sink    tok_mon,
	msgt_cfg_if.source  cfg_mon,
	output int          fail_count,
	output int          tokens_pending,
	output int          tokens_seen
);
	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value;
		logic [7:0]  ext_type;
		logic [4:0]  depth;
		logic [4:0]  closed_count;
		logic        root_done;
		logic        depth_overflow;
	} token_t;

	localparam logic [32:0] LEN_MASK = {33{1'b1}};

	token_t      token_queue[$];
	logic [32:0] lvl_count[MAX_DEPTH];
	int unsigned lvl_top;
	logic [7:0]  lead_tag;
	int unsigned hdr_left;
	logic [63:0] accum;
	logic [32:0] data_left;
	logic        ext_wait;
	logic        nest_on;

	// pop every level that this finished object completes
	function automatic int unsigned close_levels();
		int unsigned n;
		n = 0;
		while (lvl_top > 0) begin
			if (lvl_count[lvl_top - 1] <= 1) begin
				lvl_count[lvl_top - 1] = '0;
				lvl_top--;
				n++;
			end else begin
				lvl_count[lvl_top - 1]--;
				break;
			end
		end
		return n;
	endfunction

	function automatic void add_token(kind_t k, logic [63:0] v, logic [7:0] et,
			int unsigned d, logic done, logic ovf);
		token_t t;
		int unsigned c;
		c = done ? close_levels() : 0;
		t.kind = k;
		t.value = v;
		t.ext_type = et;
		t.depth = d[4:0];
		t.closed_count = c[4:0];
		t.root_done = done && lvl_top == 0;
		t.depth_overflow = ovf;
		token_queue = {token_queue, t};
	endfunction

	function automatic void open_container(kind_t k, logic [63:0] len);
		int unsigned d;
		logic [32:0] cnt;
		d = lvl_top;
		cnt = (k == K_MAP) ? ((len[32:0] << 1) & LEN_MASK) : len[32:0];
		if (nest_on && cnt != 0) begin
			if (lvl_top < MAX_DEPTH) begin
				lvl_count[lvl_top] = cnt;
				lvl_top++;
				add_token(k, len, 8'h00, d, 1'b0, 1'b0);
			end else begin
				add_token(k, len, 8'h00, d, 1'b1, 1'b1);
			end
		end else begin
			add_token(k, len, 8'h00, d, 1'b1, 1'b0);
		end
	endfunction

	function automatic void open_data(kind_t k, logic [63:0] len);
		data_left = len[32:0];
		add_token(k, len, 8'h00, lvl_top, len == 0, 1'b0);
	endfunction

	function automatic void finish_header();
		logic [63:0] v;
		int unsigned bits;
		v = accum;
		if (lead_tag >= 8'hCC && lead_tag <= 8'hCF) begin
			add_token(K_UINT, v, 8'h00, lvl_top, 1'b1, 1'b0);
		end else if (lead_tag >= 8'hD0 && lead_tag <= 8'hD3) begin
			bits = 8 << (lead_tag - 8'hD0);
			if (bits < 64 && v[bits - 1])
				v = v | ~((64'd1 << bits) - 64'd1);
			add_token(K_INT, v, 8'h00, lvl_top, 1'b1, 1'b0);
		end else if (lead_tag == 8'hCA) begin
			add_token(K_F32, v, 8'h00, lvl_top, 1'b1, 1'b0);
		end else if (lead_tag == 8'hCB) begin
			add_token(K_F64, v, 8'h00, lvl_top, 1'b1, 1'b0);
		end else if (lead_tag >= 8'hC4 && lead_tag <= 8'hC6) begin
			open_data(K_BIN, v);
		end else if (lead_tag >= 8'hD9 && lead_tag <= 8'hDB) begin
			open_data(K_STR, v);
		end else if (lead_tag >= 8'hC7 && lead_tag <= 8'hC9) begin
			ext_wait = 1'b1;
		end else if (lead_tag == 8'hDC || lead_tag == 8'hDD) begin
			open_container(K_ARRAY, v);
		end else begin
			open_container(K_MAP, v);
		end
	endfunction

	function automatic int unsigned byte_count(logic [7:0] b);
		case (b)
			8'hCC, 8'hD0, 8'hC4, 8'hC7, 8'hD9: return 1;
			8'hCD, 8'hD1, 8'hC5, 8'hC8, 8'hDA, 8'hDC, 8'hDE: return 2;
			8'hCE, 8'hD2, 8'hCA, 8'hC6, 8'hC9, 8'hDB, 8'hDD, 8'hDF: return 4;
			8'hCF, 8'hD3, 8'hCB: return 8;
			default: return 0;
		endcase
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		if (data_left > 0) begin
			data_left--;
			add_token(K_PAYLOAD, {56'd0, b}, 8'h00, lvl_top, data_left == 0, 1'b0);
		end else if (ext_wait) begin
			ext_wait = 1'b0;
			data_left = accum[32:0];
			add_token(K_EXT, accum, b, lvl_top, data_left == 0, 1'b0);
		end else if (hdr_left > 0) begin
			accum = {accum[55:0], b};
			hdr_left--;
			if (hdr_left == 0)
				finish_header();
		end else if (b < FIX_MAP_BASE) begin
			add_token(K_UINT, {56'd0, b}, 8'h00, lvl_top, 1'b1, 1'b0);
		end else if (b >= FIX_NEG_BASE) begin
			add_token(K_INT, {56'hFFFFFFFFFFFFFF, b}, 8'h00, lvl_top, 1'b1, 1'b0);
		end else if (b < 8'h90) begin
			open_container(K_MAP, {60'd0, b[3:0]});
		end else if (b < 8'hA0) begin
			open_container(K_ARRAY, {60'd0, b[3:0]});
		end else if (b < 8'hC0) begin
			open_data(K_STR, {59'd0, b[4:0]});
		end else if (b <= 8'hC3) begin
			add_token(kind_t'({2'b00, b[1:0]}), 64'd0, 8'h00, lvl_top, 1'b1, 1'b0);
		end else if (b >= 8'hD4 && b <= 8'hD8) begin
			lead_tag = b;
			accum = 64'd1 << (b - 8'hD4);
			ext_wait = 1'b1;
		end else begin
			lead_tag = b;
			accum = '0;
			hdr_left = (b >= 8'hC4 && b <= 8'hDF) ? byte_count(b) : 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_t got;
		token_t want;
		if (!arst_n) begin
			token_queue.delete();
			for (int i = 0; i < MAX_DEPTH; i++)
				lvl_count[i] = '0;
			lvl_top = 0;
			lead_tag = '0;
			hdr_left = 0;
			accum = '0;
			data_left = '0;
			ext_wait = 1'b0;
			nest_on = 1'b1;
			fail_count <= 0;
			tokens_seen <= 0;
			tokens_pending <= 0;
		end else begin
			// check first: a token is registered only after its byte is captured and decoded
			if (tok_mon.valid && tok_mon.ready) begin
				got = '{tok_mon.kind, tok_mon.value, tok_mon.ext_type, tok_mon.depth,
					tok_mon.closed_count, tok_mon.root_done, tok_mon.depth_overflow};
				tokens_seen <= tokens_seen + 1;
				if (token_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected token kind=%0d value=%h", got.kind, got.value);
					fail_count <= fail_count + 1;
				end else begin
					want = token_queue.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display("token mismatch: exp k=%0d v=%h e=%h d=%0d c=%0d r=%b o=%b",
								want.kind, want.value, want.ext_type, want.depth,
								want.closed_count, want.root_done, want.depth_overflow);
							$display("                got k=%0d v=%h e=%h d=%0d c=%0d r=%b o=%b",
								got.kind, got.value, got.ext_type, got.depth,
								got.closed_count, got.root_done, got.depth_overflow);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_mon.valid && cfg_mon.ready)
				nest_on = cfg_mon.track_nesting;
			if (bytes_mon.valid && bytes_mon.ready)
				predict_byte(bytes_mon.in_byte);
			tokens_pending <= token_queue.size();
		end
	end
endmodule

FILE: verif/msgpack_stream_tokenizer_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the MessagePack tokenizer testbench.
module msgpack_stream_tokenizer_test;

	localparam int unsigned MAX_DEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 60;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   tokens_pending;
	int   tokens_seen;
	int   bytes_sent;
	int   cycle_count;
	int   stall_mode;
	int   hold_off;
	logic hold_start;

	msgt_byte_if bytes_ch();
	msgt_tok_if  tok_ch();
	msgt_cfg_if  cfg_ch();

	msgpack_stream_tokenizer #(.MAX_DEPTH(MAX_DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n), .bytes(bytes_ch), .tokens(tok_ch), .cfg(cfg_ch));

	msgt_token_checker #(.MAX_DEPTH(MAX_DEPTH)) u_chk (
		.clk(clk), .arst_n(arst_n), .bytes_mon(bytes_ch), .tok_mon(tok_ch),
		.cfg_mon(cfg_ch), .fail_count(fail_count), .tokens_pending(tokens_pending),
		.tokens_seen(tokens_seen));

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Bytes waiting to be offered; filled by the stream builders below.
	logic [7:0] byte_queue[$];

	// Receiver: random stalls in several moods, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (hold_off > 0)
				tok_ch.ready <= 1'b0;
			else case (stall_mode)
				0: tok_ch.ready <= 1'b1;
				1: tok_ch.ready <= ($urandom_range(0, 3) != 0);
				default: tok_ch.ready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	// Count the long hold-off down, started by a pulse from the stimulus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_off <= 0;
		else if (hold_start)
			hold_off <= HOLD_CYCLES;
		else if (hold_off > 0)
			hold_off <= hold_off - 1;
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Queue helpers: append one byte.
	task automatic put_byte(logic [7:0] b);
		byte_queue = {byte_queue, b};
	endtask

	// Append a big-endian number of n bytes.
	task automatic put_be(logic [63:0] v, int n);
		for (int i = n - 1; i >= 0; i--)
			put_byte(v[i*8 +: 8]);
	endtask

	// Append one random well-formed object, nesting up to lvl.
	task automatic put_object(int lvl);
		int sel;
		int len;
		sel = $urandom_range(0, 15);
		if (lvl <= 0 && sel >= 12)
			sel = $urandom_range(0, 11);
		case (sel)
			0: put_byte(8'($urandom_range(0, 127)));
			1: put_byte(8'($urandom_range(8'hE0, 8'hFF)));
			2: put_byte(8'($urandom_range(8'hC0, 8'hC3)));
			3: begin
				put_byte(8'($urandom_range(8'hCC, 8'hCF)));
				put_be({$urandom, $urandom}, 1 << (byte_queue[$] - 8'hCC));
			end
			4: begin
				put_byte(8'($urandom_range(8'hD0, 8'hD3)));
				put_be({$urandom, $urandom}, 1 << (byte_queue[$] - 8'hD0));
			end
			5: begin
				put_byte(8'hCA);
				put_be({32'd0, $urandom}, 4);
			end
			6: begin
				put_byte(8'hCB);
				put_be({$urandom, $urandom}, 8);
			end
			7: begin
				len = $urandom_range(0, 31);
				put_byte(8'hA0 | 8'(len));
				repeat (len) put_byte(8'($urandom));
			end
			8, 9: begin
				len = $urandom_range(0, 6);
				// str8/16/32 or bin8/16/32
				put_byte(sel == 8 ? 8'($urandom_range(8'hD9, 8'hDB)) :
					8'($urandom_range(8'hC4, 8'hC6)));
				put_be(64'(len), (byte_queue[$] == 8'hD9 || byte_queue[$] == 8'hC4) ? 1 :
					(byte_queue[$] == 8'hDA || byte_queue[$] == 8'hC5) ? 2 : 4);
				repeat (len) put_byte(8'($urandom));
			end
			10: begin
				// fixext with its data
				put_byte(8'($urandom_range(8'hD4, 8'hD8)));
				len = 1 << (byte_queue[$] - 8'hD4);
				put_byte(8'($urandom));
				repeat (len) put_byte(8'($urandom));
			end
			11: begin
				len = $urandom_range(0, 5);
				put_byte(8'($urandom_range(8'hC7, 8'hC9)));
				put_be(64'(len), byte_queue[$] == 8'hC7 ? 1 : byte_queue[$] == 8'hC8 ? 2 : 4);
				put_byte(8'($urandom));
				repeat (len) put_byte(8'($urandom));
			end
			12, 13: begin
				len = $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0) begin
					put_byte(8'hDC);
					put_be(64'(len), 2);
				end else put_byte(8'h90 | 8'(len));
				repeat (len) put_object(lvl - 1);
			end
			default: begin
				len = $urandom_range(0, 2);
				if ($urandom_range(0, 3) == 0) begin
					put_byte(8'hDF);
					put_be(64'(len), 4);
				end else put_byte(8'h80 | 8'(len));
				repeat (2 * len) put_object(lvl - 1);
			end
		endcase
	endtask

	// Offer the queued bytes in bursts with random gaps.
	task automatic send_queue();
		int burst;
		while (byte_queue.size() > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && byte_queue.size() > 0) begin
				bytes_ch.valid <= 1'b1;
				bytes_ch.in_byte <= byte_queue.pop_front();
				@(posedge clk);
				while (!bytes_ch.ready) @(posedge clk);
				bytes_sent++;
				burst--;
			end
			if ($urandom_range(0, 2) != 0) begin
				bytes_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		bytes_ch.valid <= 1'b0;
	endtask

	// Drain: wait for every token, then let the block settle before a write.
	task automatic drain();
		@(posedge clk);
		while (tokens_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		while (tokens_pending != 0) @(posedge clk);
	endtask

	task automatic set_nesting(logic on);
		cfg_ch.valid <= 1'b1;
		cfg_ch.track_nesting <= on;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		bytes_ch.valid = 1'b0;
		bytes_ch.in_byte = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.track_nesting = 1'b1;
		stall_mode = 0;
		hold_start = 1'b0;
		bytes_sent = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes and empty containers; BF opens a 31-byte str.
		byte_queue = '{8'h00, 8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0, 8'hBF, 8'hC0,
			8'hC1, 8'hC2, 8'hC3, 8'hE0, 8'hFF};
		// after the str payload, fixints feed the open map and array; AA is a fixstr
		repeat (15) put_byte(8'h01);
		repeat (32) put_byte(8'hFF);
		put_byte(8'h55);
		put_byte(8'hAA);
		send_queue();
		// ten payload bytes for the AA fixstr, fixints, then a zero-length ext
		byte_queue = '{8'hD0, 8'h80, 8'hD1, 8'h80, 8'h00, 8'hD3, 8'h80, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC7, 8'h00, 8'hFF};
		send_queue();
		// deeper than the stack: seventeen one-element arrays then two leaves
		repeat (17) put_byte(8'h91);
		put_byte(8'h00);
		put_byte(8'h00);
		send_queue();
		drain();

		// Nesting off: three container headers and a fixint, no new levels.
		set_nesting(1'b0);
		byte_queue = '{8'h93, 8'h82, 8'hDD, 8'h00, 8'h00, 8'h00, 8'h05, 8'h01};
		send_queue();
		drain();
		set_nesting(1'b1);

		// Random phases: well-formed objects, with some raw noise.
		for (int phase = 0; phase < 6; phase++) begin
			stall_mode = phase % 3;
			if (phase == 3)
				set_nesting(1'b0);
			if (phase == 4)
				set_nesting(1'b1);
			repeat (7) begin
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(1, 4))
						put_byte(8'($urandom_range(0, 127)));
				else
					put_object(phase == 5 ? 20 : 4);
			end
			// one long receiver hold-off while bytes keep coming
			if (phase == 1) begin
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			send_queue();
			drain();
		end

		$display("sent %0d bytes, checked %0d tokens across nesting on and off",
			bytes_sent, tokens_seen);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

FILE: sim.f
sv/msgt_pkg.sv
sv/msgt_if.sv
sv/msgt_ram.sv
sv/msgpack_stream_tokenizer.sv
verif/msgt_token_checker.sv
verif/msgpack_stream_tokenizer_test.sv
